### rtl/tms_pkg.sv
package tms_pkg;

  localparam int unsigned HZ_W    = 12;
  localparam int unsigned MS_W    = 8;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned ROM_AW  = 4;
  localparam int unsigned CLICK_W = 4;
  localparam int unsigned HOUR_W  = 5;

  localparam logic [HZ_W-1:0]    CLICK_HZ = 12'd4000;
  localparam logic [CLICK_W-1:0] CLICK_MS = 4'd8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PLAY  = 2'd1,
    OP_CLICK = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_SOUND_EN    = 2'd0,
    CFG_CLICK_EN    = 2'd1,
    CFG_QUIET_START = 2'd2,
    CFG_QUIET_END   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [HZ_W-1:0] hz;
    logic [MS_W-1:0] ms;
  } tone_step_t;

  function automatic tone_step_t step_rom(input logic [ROM_AW-1:0] idx);
    tone_step_t s;
    case (idx)
      4'd0:    s = '{hz: 12'd1047, ms: 8'd120};
      4'd1:    s = '{hz: 12'd0,    ms: 8'd40};
      4'd2:    s = '{hz: 12'd1319, ms: 8'd120};
      4'd3:    s = '{hz: 12'd0,    ms: 8'd40};
      4'd4:    s = '{hz: 12'd1568, ms: 8'd120};
      4'd5:    s = '{hz: 12'd0,    ms: 8'd40};
      4'd6:    s = '{hz: 12'd2093, ms: 8'd250};
      4'd7:    s = '{hz: 12'd880,  ms: 8'd100};
      4'd8:    s = '{hz: 12'd0,    ms: 8'd80};
      4'd9:    s = '{hz: 12'd880,  ms: 8'd100};
      4'd10:   s = '{hz: 12'd0,    ms: 8'd80};
      4'd11:   s = '{hz: 12'd880,  ms: 8'd100};
      4'd12:   s = '{hz: 12'd1047, ms: 8'd80};
      4'd13:   s = '{hz: 12'd0,    ms: 8'd40};
      4'd14:   s = '{hz: 12'd1568, ms: 8'd120};
      4'd15:   s = '{hz: 12'd4000, ms: 8'd8};
      default: s = '{hz: 12'd0,    ms: 8'd0};
    endcase
    return s;
  endfunction

  function automatic logic [ROM_AW-1:0] melody_base(input logic [1:0] kind);
    logic [ROM_AW-1:0] b;
    case (kind)
      2'd0:    b = 4'd0;
      2'd1:    b = 4'd7;
      2'd2:    b = 4'd12;
      2'd3:    b = 4'd15;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [STEP_W-1:0] melody_len(input logic [1:0] kind);
    logic [STEP_W-1:0] n;
    case (kind)
      2'd0:    n = 3'd7;
      2'd1:    n = 3'd5;
      2'd2:    n = 3'd3;
      2'd3:    n = 3'd1;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

### rtl/tone_melody_sequencer.sv
// Buzzer melody sequencer. Each input item is a 1 ms tick, a play request for one of four
// fixed melodies, or a button click, selected by in_tuser. The block takes one item per
// clock while its results are taken, and returns exactly one result item per input item,
// showing the tone, melody and click state after that item. An item passes an input
// register and a result register before its result reaches the output; input and output
// can both move in every cycle, and while one finished result waits at the output the
// input register takes one more item, then holds in_tready low until the result is taken.
// Configuration is accepted in any cycle and should only be written while no item is in
// flight. Melody steps come from a small constant table, and no clearing pass follows reset.
module tone_melody_sequencer
  import tms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // melody_kind[1:0], hour_now[6:2], hour_valid[7]
  input  logic [1:0]  in_tuser,   // opcode[1:0]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // tone_hz[11:0], melody_active[12], click_active[13], zero

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  logic              sound_en_r;
  logic              click_en_r;
  logic [HOUR_W-1:0] quiet_start_r;
  logic [HOUR_W-1:0] quiet_end_r;

  logic              s1_valid_r;
  logic [1:0]        s1_opcode_r;
  logic [1:0]        s1_kind_r;
  logic [HOUR_W-1:0] s1_hour_r;
  logic              s1_hour_valid_r;

  logic               playing_r, playing_nxt;
  logic [1:0]         choice_r, choice_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [MS_W-1:0]    elapsed_r, elapsed_nxt;
  logic [CLICK_W-1:0] click_r, click_nxt;

  logic            out_valid_r;
  logic [HZ_W-1:0] out_tone_r, tone_nxt;
  logic            out_melody_r;
  logic            out_click_r;

  logic              out_space;
  logic              s1_go;
  logic              quiet;
  tone_step_t        cur_step;
  tone_step_t        new_step;
  logic [MS_W-1:0]   elapsed_inc;
  logic [STEP_W-1:0] step_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_en_r    <= 1'b0;
      click_en_r    <= 1'b0;
      quiet_start_r <= '0;
      quiet_end_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SOUND_EN:    sound_en_r    <= cfg_data[0];
        CFG_CLICK_EN:    click_en_r    <= cfg_data[0];
        CFG_QUIET_START: quiet_start_r <= cfg_data;
        CFG_QUIET_END:   quiet_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_space = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_space;
  assign in_tready = !s1_valid_r || out_space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_opcode_r     <= in_tuser;
      s1_kind_r       <= in_tdata[1:0];
      s1_hour_r       <= in_tdata[6:2];
      s1_hour_valid_r <= in_tdata[7];
    end
  end

  always_comb begin
    if (quiet_start_r == quiet_end_r || !s1_hour_valid_r) begin
      quiet = 1'b0;
    end else if (quiet_start_r < quiet_end_r) begin
      quiet = (s1_hour_r >= quiet_start_r) && (s1_hour_r < quiet_end_r);
    end else begin
      quiet = (s1_hour_r >= quiet_start_r) || (s1_hour_r < quiet_end_r);
    end
  end

  assign cur_step    = step_rom(melody_base(choice_r) + {1'b0, step_r});
  assign elapsed_inc = elapsed_r + 8'd1;
  assign step_inc    = step_r + 3'd1;

  always_comb begin
    playing_nxt = playing_r;
    choice_nxt  = choice_r;
    step_nxt    = step_r;
    elapsed_nxt = elapsed_r;
    click_nxt   = click_r;
    case (s1_opcode_r)
      OP_TICK: begin
        if (click_r != '0) begin
          click_nxt = click_r - 4'd1;
          if (click_r == 4'd1 && playing_r) begin
            elapsed_nxt = '0;
          end
        end else if (playing_r) begin
          if (elapsed_inc >= cur_step.ms) begin
            elapsed_nxt = '0;
            if (step_inc >= melody_len(choice_r)) begin
              playing_nxt = 1'b0;
              step_nxt    = '0;
            end else begin
              step_nxt = step_inc;
            end
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
      OP_PLAY: begin
        if (sound_en_r && !playing_r && click_r == '0 && !quiet) begin
          choice_nxt  = s1_kind_r;
          step_nxt    = '0;
          elapsed_nxt = '0;
          playing_nxt = 1'b1;
        end
      end
      OP_CLICK: begin
        if (sound_en_r && click_en_r && click_r == '0) begin
          click_nxt = CLICK_MS;
        end
      end
      default: ;
    endcase
  end

  assign new_step = step_rom(melody_base(choice_nxt) + {1'b0, step_nxt});

  always_comb begin
    if (click_nxt != '0) begin
      tone_nxt = CLICK_HZ;
    end else if (playing_nxt) begin
      tone_nxt = new_step.hz;
    end else begin
      tone_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      choice_r  <= '0;
      step_r    <= '0;
      elapsed_r <= '0;
      click_r   <= '0;
    end else if (s1_go) begin
      playing_r <= playing_nxt;
      choice_r  <= choice_nxt;
      step_r    <= step_nxt;
      elapsed_r <= elapsed_nxt;
      click_r   <= click_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_space) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_tone_r   <= tone_nxt;
      out_melody_r <= playing_nxt;
      out_click_r  <= (click_nxt != '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_click_r, out_melody_r, out_tone_r};

`ifndef SYNTHESIS
  a_click_bound: assert property (@(posedge clk) disable iff (!rst_n)
    click_r <= CLICK_MS)
    else $error("click counter above its start value");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !playing_r |-> (step_r == '0))
    else $error("step number not cleared while no melody plays");

  a_step_in_melody: assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> (step_r < melody_len(choice_r)))
    else $error("step number beyond the melody length");

  a_click_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_click_r) |-> (out_tone_r == CLICK_HZ))
    else $error("click result without click tone");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !s1_valid_r) |=> !out_valid_r)
    else $error("result repeated after it was taken");
`endif

endmodule
